@@ rtl/core/miller_rabin_round_defines.svh @@
// Assertion macros used by the miller_rabin_round checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MILLER_RABIN_ROUND_DEFINES_SVH
`define MILLER_RABIN_ROUND_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mr_pkg.sv @@
// Package for the Miller-Rabin round block: widths, payload structs, codes,
// sequencer states and the modular add helper. No dependencies.
package mr_pkg;

    localparam int MR_W     = 32;
    localparam int MR_CNT_W = $clog2(MR_W);

    typedef logic [MR_W-1:0]     t_word;
    typedef logic [MR_CNT_W-1:0] t_cnt;

    typedef enum logic [1:0] {
        ST_COMPOSITE = 2'd0,
        ST_PROBABLE  = 2'd1,
        ST_BAD_BASE  = 2'd2
    } t_status;

    typedef struct packed {
        t_word candidate;
        t_word base;
        logic  last_base;
    } t_in;

    typedef struct packed {
        t_status status;
        logic    overall_prime;
        logic    run_done;
    } t_out;

    typedef struct packed {
        logic  start;
        t_word x;
        t_word y;
        t_word n;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word prod;
    } t_mul_rsp;

    typedef struct packed {
        logic    valid;
        t_status status;
        logic    last;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPLIT,
        S_POW,
        S_WAIT_R,
        S_ISSUE_A,
        S_WAIT_A,
        S_CHK,
        S_SQ,
        S_WAIT_X,
        S_DONE
    } t_state;

    // (x + y) mod n for x, y < n
    function automatic t_word add_mod(input t_word x, input t_word y, input t_word n);
        logic [MR_W:0] sum;
        logic [MR_W:0] red;
        sum = {1'b0, x} + {1'b0, y};
        red = sum - {1'b0, n};
        return (sum >= {1'b0, n}) ? red[MR_W-1:0] : sum[MR_W-1:0];
    endfunction

endpackage

@@ rtl/core/mr_mulmod.sv @@
// Shift-add modular multiplier, one multiplier bit per cycle.
// Depends on mr_pkg.
module mr_mulmod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mr_pkg::t_mul_req i_req,
    output mr_pkg::t_mul_rsp o_rsp
);
    import mr_pkg::*;

    logic  r_busy;
    t_word r_x;
    t_word r_y;
    t_word r_n;
    t_word r_acc;
    logic  done;

    assign done       = r_busy && (r_y == '0);
    assign o_rsp.done = done;
    assign o_rsp.prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.x;
            r_y   <= i_req.y;
            r_n   <= i_req.n;
            r_acc <= '0;
        end else if (r_busy && (r_y != '0)) begin
            if (r_y[0]) begin
                r_acc <= add_mod(r_acc, r_x, r_n);
            end
            r_x <= add_mod(r_x, r_x, r_n);
            r_y <= r_y >> 1;
        end
    end

endmodule

@@ rtl/core/mr_ctrl.sv @@
// Round sequencer: special cases, split of n-1, modular power and squaring loop.
// Depends on mr_pkg; drives the shared mr_mulmod unit.
module mr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  mr_pkg::t_in      i_in_data,
    output logic             o_in_stall,
    output mr_pkg::t_mul_req o_mul_req,
    input  mr_pkg::t_mul_rsp i_mul_rsp,
    output mr_pkg::t_res     o_res,
    input  logic             i_res_taken
);
    import mr_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_word   r_n;
    t_word   r_a;
    t_word   r_d;
    t_word   r_x;
    t_cnt    r_s;
    t_cnt    r_cnt;
    t_status r_status;
    logic    r_last;

    logic    accept;
    logic    special;
    t_status spec_status;
    t_word   in_n;
    t_word   in_a;
    t_word   nm1;
    logic    sq_end;
    logic    sq_hit;

    assign in_n   = i_in_data.candidate;
    assign in_a   = i_in_data.base;
    assign accept = i_in_valid && !o_in_stall;
    assign nm1    = r_n - t_word'(1);
    assign sq_end = (r_cnt == r_s);
    assign sq_hit = (r_x == nm1);

    always_comb begin
        special     = 1'b1;
        spec_status = ST_BAD_BASE;
        if (in_n == t_word'(2)) begin
            spec_status = ST_PROBABLE;
        end else if (!in_n[0] || (in_n < t_word'(2))) begin
            spec_status = ST_COMPOSITE;
        end else if ((in_a < t_word'(2)) || (in_a >= in_n)) begin
            spec_status = ST_BAD_BASE;
        end else begin
            special = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = special ? S_DONE : S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (r_d[0]) begin
                    n_state = S_POW;
                end
            end
            S_POW: begin
                if (r_d == '0) begin
                    n_state = S_CHK;
                end else if (r_d[0]) begin
                    n_state = S_WAIT_R;
                end else begin
                    n_state = S_WAIT_A;
                end
            end
            S_WAIT_R: begin
                if (i_mul_rsp.done) begin
                    n_state = S_ISSUE_A;
                end
            end
            S_ISSUE_A: begin
                n_state = S_WAIT_A;
            end
            S_WAIT_A: begin
                if (i_mul_rsp.done) begin
                    n_state = S_POW;
                end
            end
            S_CHK: begin
                n_state = (r_x == t_word'(1)) ? S_DONE : S_SQ;
            end
            S_SQ: begin
                n_state = (sq_end || sq_hit) ? S_DONE : S_WAIT_X;
            end
            S_WAIT_X: begin
                if (i_mul_rsp.done) begin
                    n_state = S_SQ;
                end
            end
            S_DONE: begin
                if (i_res_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        o_res.valid     = (r_state == S_DONE);
        o_res.status    = r_status;
        o_res.last      = r_last;
        o_mul_req.start = 1'b0;
        o_mul_req.x     = r_x;
        o_mul_req.y     = r_a;
        o_mul_req.n     = r_n;
        unique case (r_state)
            S_POW: begin
                if (r_d != '0) begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.x     = r_d[0] ? r_x : r_a;
                end
            end
            S_ISSUE_A: begin
                o_mul_req.start = 1'b1;
                o_mul_req.x     = r_a;
            end
            S_SQ: begin
                if (!sq_end && !sq_hit) begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.y     = r_x;
                end
            end
            default: begin
                o_mul_req.start = 1'b0;
            end
        endcase
    end

    // datapath; r_d doubles as the exponent once the split is done
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_n      <= in_n;
                    r_a      <= in_a;
                    r_d      <= in_n - t_word'(1);
                    r_x      <= t_word'(1);
                    r_s      <= '0;
                    r_cnt    <= '0;
                    r_last   <= i_in_data.last_base;
                    r_status <= special ? spec_status : ST_COMPOSITE;
                end
            end
            S_SPLIT: begin
                if (!r_d[0]) begin
                    r_d <= r_d >> 1;
                    r_s <= r_s + t_cnt'(1);
                end
            end
            S_WAIT_R: begin
                if (i_mul_rsp.done) begin
                    r_x <= i_mul_rsp.prod;
                end
            end
            S_WAIT_A: begin
                if (i_mul_rsp.done) begin
                    r_a <= i_mul_rsp.prod;
                    r_d <= r_d >> 1;
                end
            end
            S_CHK: begin
                if (r_x == t_word'(1)) begin
                    r_status <= ST_PROBABLE;
                end
            end
            S_SQ: begin
                if (sq_end) begin
                    r_status <= ST_COMPOSITE;
                end else if (sq_hit) begin
                    r_status <= ST_PROBABLE;
                end
            end
            S_WAIT_X: begin
                if (i_mul_rsp.done) begin
                    r_x   <= i_mul_rsp.prod;
                    r_cnt <= r_cnt + t_cnt'(1);
                end
            end
            default: begin
                r_last <= r_last;
            end
        endcase
    end

endmodule

@@ rtl/core/miller_rabin_round.sv @@
// Miller-Rabin round, top level: sequencer, shared modular multiplier, result
// register and run flag. Depends on mr_pkg, mr_ctrl and mr_mulmod.
//
// One transfer in gives one transfer out. Candidate two, even candidates,
// candidates up to one and out-of-range bases go straight to the result
// without any multiplication. A full round takes one modular multiplication
// per set exponent bit and one per exponent bit for squaring the base, then
// up to s squarings, where n-1 = d * 2^s. Each multiplication runs one bit
// of its multiplier per cycle on the single shift-add unit. The input stays
// stalled until the result is loaded into the output register; a result
// still waiting there does not block the next input transfer.
module miller_rabin_round (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  mr_pkg::t_in i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output mr_pkg::t_out o_out_data
);
    import mr_pkg::*;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_res     res;
    logic     res_taken;
    logic     res_comp;
    logic     r_out_valid;
    t_out     r_out_data;
    logic     r_run_flag;

    mr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_mul_req   (mul_req),
        .i_mul_rsp   (mul_rsp),
        .o_res       (res),
        .i_res_taken (res_taken)
    );

    mr_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign res_taken = res.valid && (!r_out_valid || !i_out_stall);
    assign res_comp  = (res.status == ST_COMPOSITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_run_flag  <= 1'b0;
        end else begin
            if (res_taken) begin
                r_out_valid <= 1'b1;
                r_run_flag  <= res.last ? 1'b0 : (r_run_flag || res_comp);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_taken) begin
            r_out_data.status        <= res.status;
            r_out_data.overall_prime <= res.last && !r_run_flag && !res_comp;
            r_out_data.run_done      <= res.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/core/mr_checker.sv @@
// Port-level checker for miller_rabin_round, bound to the top level.
// Depends on mr_pkg and miller_rabin_round_defines.svh.
`include "miller_rabin_round_defines.svh"

module mr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         o_in_stall,
    input logic         o_out_valid,
    input logic         i_out_stall,
    input mr_pkg::t_out o_out_data
);
    import mr_pkg::*;

    `MR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "stalled result changed")
    `MR_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "input not stalled after transfer")
    `MR_ASSERT_NOW(a_prime_needs_done, i_clk, i_rst_n,
        o_out_valid && o_out_data.overall_prime, o_out_data.run_done,
        "overall verdict without run end")
    `MR_ASSERT_NOW(a_comp_not_prime, i_clk, i_rst_n,
        o_out_valid && (o_out_data.status == ST_COMPOSITE), !o_out_data.overall_prime,
        "composite round with prime verdict")

endmodule

bind miller_rabin_round mr_checker u_mr_checker (.*);
